FILE: rtl/lfu_pkg.sv
// Shared types and codes for the least-frequently-used key-value cache
`default_nettype none
package lfu_pkg;
    localparam int ENTRIES = 16;

    localparam logic [1:0] FUNC_GET = 2'd0;
    localparam logic [1:0] FUNC_PUT = 2'd1;
    localparam logic [1:0] FUNC_POP = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISS     = 2'd1;
    localparam logic [1:0] STATUS_POP_OVER = 2'd2;

    localparam logic [0:0] REG_CAPACITY = 1'd0;

    // Per-cycle command broadcast from the controller to every cell
    typedef struct packed {
        logic scan;       // cells forward scan data this cycle
        logic evict;      // cell matching victim index clears its valid bit
        logic bump;       // cell matching hit index raises its count
        logic write_val;  // cell matching hit index takes the new value
        logic insert;     // cell matching insert index (free or victim slot) takes the new entry
    } cell_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/lfu_cell.sv
// One cache slot: holds an entry and folds it into the scan passed along the row
`default_nettype none
module lfu_cell #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16,
    parameter int IDX_BITS   = 4,
    parameter int SLOT       = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lfu_pkg::cell_cmd_t    cmd,
    input  wire logic [IDX_BITS-1:0]   tgt_idx,
    input  wire logic [IDX_BITS-1:0]   ins_idx,
    input  wire logic [KEY_BITS-1:0]   in_key,
    input  wire logic [VALUE_BITS-1:0] in_value,
    input  wire logic [31:0]           seq,
    // scan data arriving from the previous cell
    input  wire logic                  hit_in,
    input  wire logic [IDX_BITS-1:0]   hit_idx_in,
    input  wire logic [VALUE_BITS-1:0] hit_val_in,
    input  wire logic                  vic_in,
    input  wire logic [IDX_BITS-1:0]   vic_idx_in,
    input  wire logic [KEY_BITS-1:0]   vic_key_in,
    input  wire logic [COUNT_BITS-1:0] vic_cnt_in,
    input  wire logic [31:0]           vic_age_in,
    input  wire logic                  free_in,
    input  wire logic [IDX_BITS-1:0]   free_idx_in,
    // scan data handed to the next cell
    output logic                       hit_out,
    output logic [IDX_BITS-1:0]        hit_idx_out,
    output logic [VALUE_BITS-1:0]      hit_val_out,
    output logic                       vic_out,
    output logic [IDX_BITS-1:0]        vic_idx_out,
    output logic [KEY_BITS-1:0]        vic_key_out,
    output logic [COUNT_BITS-1:0]      vic_cnt_out,
    output logic [31:0]                vic_age_out,
    output logic                       free_out,
    output logic [IDX_BITS-1:0]        free_idx_out
);
    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(SLOT);

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [31:0]           stamp_reg;
    logic [31:0]           age;
    logic                  beats;

    assign age   = seq - stamp_reg;
    assign beats = valid_reg && (!vic_in || count_reg < vic_cnt_in ||
                   (count_reg == vic_cnt_in && age < vic_age_in));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            hit_out      <= 1'b0;
            vic_out      <= 1'b0;
            free_out     <= 1'b0;
        end
        else
        begin
            if (cmd.evict && tgt_idx == MY_IDX)
                valid_reg <= 1'b0;
            if (cmd.insert && ins_idx == MY_IDX)
                valid_reg <= 1'b1;
            if (cmd.scan)
            begin
                hit_out  <= hit_in || (valid_reg && key_reg == in_key);
                vic_out  <= vic_in || valid_reg;
                free_out <= free_in || !valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bump && tgt_idx == MY_IDX && count_reg != {COUNT_BITS{1'b1}})
            count_reg <= count_reg + 1'b1;
        if (cmd.write_val && tgt_idx == MY_IDX)
            value_reg <= in_value;
        if (cmd.insert && ins_idx == MY_IDX)
        begin
            key_reg   <= in_key;
            value_reg <= in_value;
            count_reg <= COUNT_BITS'(1);
            stamp_reg <= seq;
        end
        if (cmd.scan)
        begin
            if (!hit_in && valid_reg && key_reg == in_key)
            begin
                hit_idx_out <= MY_IDX;
                hit_val_out <= value_reg;
            end
            else
            begin
                hit_idx_out <= hit_idx_in;
                hit_val_out <= hit_val_in;
            end
            if (beats)
            begin
                vic_idx_out <= MY_IDX;
                vic_key_out <= key_reg;
                vic_cnt_out <= count_reg;
                vic_age_out <= age;
            end
            else
            begin
                vic_idx_out <= vic_idx_in;
                vic_key_out <= vic_key_in;
                vic_cnt_out <= vic_cnt_in;
                vic_age_out <= vic_age_in;
            end
            free_idx_out <= (!free_in && !valid_reg) ? MY_IDX : free_idx_in;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lfu_key_value_cache_unit.sv
// Top level: controller, configuration port and the row of slot cells
//  channel | valid     | stall     | beat payload
//  input   | in_valid  | in_stall  | func, lookup_key, put_value, pop_count
//  output  | out_valid | out_stall | status, read_value, evicted, evicted_key,
//          |           |           | occupancy, last
//  config  | APB write/read, capacity at byte address 0
// A get or put scans the row, acts, then loads the result; the input stays stalled until
// the controller is back in idle, which it reaches only once the result is not stalled,
// so a new item is taken only after the last one is through.
// A pop rescans for each eviction and gives one result per eviction. A pop of zero
// or of too many, or an unused func, answers without a scan.
// Reset clears all valid bits at once; a stalled result holds the controller in its wait state.
`default_nettype none
module lfu_key_value_cache_unit #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            func,
    input  wire logic [KEY_BITS-1:0]   lookup_key,
    input  wire logic [VALUE_BITS-1:0] put_value,
    input  wire logic [4:0]            pop_count,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 status,
    output logic [VALUE_BITS-1:0]      read_value,
    output logic                       evicted,
    output logic [KEY_BITS-1:0]        evicted_key,
    output logic [4:0]                 occupancy,
    output logic                       last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [0:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    localparam int ENTRIES  = lfu_pkg::ENTRIES;
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int OCC_BITS = $clog2(ENTRIES + 1);
    localparam int CNT_BITS = $clog2(ENTRIES + 2);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_ACT   = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_WAIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]            cap_reg;
    logic [31:0]           seq_reg;
    logic [1:0]            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [4:0]            left_reg;
    logic [CNT_BITS-1:0]   step_reg;
    logic [OCC_BITS-1:0]   occ_reg;
    lfu_pkg::cell_cmd_t    cmd;
    logic [IDX_BITS-1:0]   tgt_idx, ins_idx;
    logic                  ev_reg;
    logic [KEY_BITS-1:0]   ek_reg;

    logic [ENTRIES:0]                 hit_c, vic_c, free_c;
    logic [IDX_BITS-1:0]              hit_idx_c [ENTRIES+1];
    logic [VALUE_BITS-1:0]            hit_val_c [ENTRIES+1];
    logic [IDX_BITS-1:0]              vic_idx_c [ENTRIES+1];
    logic [KEY_BITS-1:0]              vic_key_c [ENTRIES+1];
    logic [COUNT_BITS-1:0]            vic_cnt_c [ENTRIES+1];
    logic [31:0]                      vic_age_c [ENTRIES+1];
    logic [IDX_BITS-1:0]              free_idx_c [ENTRIES+1];

    // chain head: nothing found yet
    assign hit_c[0]      = 1'b0;
    assign vic_c[0]      = 1'b0;
    assign free_c[0]     = 1'b0;
    assign hit_idx_c[0]  = '0;
    assign hit_val_c[0]  = '0;
    assign vic_idx_c[0]  = '0;
    assign vic_key_c[0]  = '0;
    assign vic_cnt_c[0]  = '0;
    assign vic_age_c[0]  = '0;
    assign free_idx_c[0] = '0;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            lfu_cell #(
                .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
                .COUNT_BITS(COUNT_BITS), .IDX_BITS(IDX_BITS), .SLOT(g)
            ) u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd), .tgt_idx(tgt_idx),
                .ins_idx(ins_idx), .in_key(key_reg), .in_value(val_reg),
                .seq(seq_reg),
                .hit_in(hit_c[g]), .hit_idx_in(hit_idx_c[g]),
                .hit_val_in(hit_val_c[g]), .vic_in(vic_c[g]),
                .vic_idx_in(vic_idx_c[g]), .vic_key_in(vic_key_c[g]),
                .vic_cnt_in(vic_cnt_c[g]), .vic_age_in(vic_age_c[g]),
                .free_in(free_c[g]), .free_idx_in(free_idx_c[g]),
                .hit_out(hit_c[g+1]), .hit_idx_out(hit_idx_c[g+1]),
                .hit_val_out(hit_val_c[g+1]), .vic_out(vic_c[g+1]),
                .vic_idx_out(vic_idx_c[g+1]), .vic_key_out(vic_key_c[g+1]),
                .vic_cnt_out(vic_cnt_c[g+1]), .vic_age_out(vic_age_c[g+1]),
                .free_out(free_c[g+1]), .free_idx_out(free_idx_c[g+1])
            );
        end
    endgenerate

    logic hit, full;
    logic [4:0] cap_eff;
    logic [OCC_BITS-1:0] occ_after;
    assign hit     = hit_c[ENTRIES];
    assign cap_eff = (cap_reg == 5'd0) ? 5'd1 :
                     (32'(cap_reg) > ENTRIES) ? 5'(ENTRIES) : cap_reg;
    assign full    = 32'(occ_reg) >= 32'(cap_eff);

    assign pready = 1'b1;
    assign prdata = (paddr == lfu_pkg::REG_CAPACITY) ? {27'd0, cap_reg} : 32'd0;
    assign in_stall  = (state_reg != ST_IDLE);
    assign occupancy = 5'(occ_reg);

    // scan drives the chain only while it runs
    always_comb
    begin
        cmd = '0;
        tgt_idx = hit ? hit_idx_c[ENTRIES] : vic_idx_c[ENTRIES];
        ins_idx = free_idx_c[ENTRIES];
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // immediate results need no scan
                    if ((func == lfu_pkg::FUNC_POP &&
                         (pop_count == 5'd0 || 32'(pop_count) > 32'(occ_reg))) ||
                        (func != lfu_pkg::FUNC_GET && func != lfu_pkg::FUNC_PUT &&
                         func != lfu_pkg::FUNC_POP))
                        state_next = ST_EMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (32'(step_reg) == ENTRIES) state_next = ST_ACT;
            end
            ST_ACT:  state_next = ST_EMIT;
            ST_EMIT: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (!out_valid || !out_stall)
                begin
                    if (func_reg == lfu_pkg::FUNC_POP && ev_reg && left_reg > 5'd1)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_ACT)
        begin
            case (func_reg)
                lfu_pkg::FUNC_GET: cmd.bump = hit;
                lfu_pkg::FUNC_PUT:
                begin
                    cmd.bump      = hit;
                    cmd.write_val = hit;
                    cmd.evict     = !hit && full && vic_c[ENTRIES];
                    // free slot chosen after eviction: take victim slot if none was free or if it has the lower index
                    cmd.insert    = !hit;
                    if (!hit && !free_c[ENTRIES]) ins_idx = vic_idx_c[ENTRIES];
                    else if (!hit && full && vic_c[ENTRIES] &&
                             vic_idx_c[ENTRIES] < free_idx_c[ENTRIES])
                        ins_idx = vic_idx_c[ENTRIES];
                end
                lfu_pkg::FUNC_POP:
                begin
                    // a pop ignores any key match
                    tgt_idx   = vic_idx_c[ENTRIES];
                    cmd.evict = vic_c[ENTRIES];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        occ_after = occ_reg;
        if (cmd.evict) occ_after = occ_after - 1'b1;
        if (cmd.insert) occ_after = occ_after + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= 5'd16;
            seq_reg   <= 32'd0;
            occ_reg   <= '0;
            out_valid <= 1'b0;
            step_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == lfu_pkg::REG_CAPACITY)
                cap_reg <= pwdata[4:0];
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid)
                    begin
                        func_reg <= func;
                        key_reg  <= lookup_key;
                        val_reg  <= put_value;
                        left_reg <= pop_count;
                        ev_reg   <= 1'b0;
                        ek_reg   <= '0;
                    end
                end
                ST_SCAN: step_reg <= step_reg + 1'b1;
                ST_ACT:
                begin
                    occ_reg <= occ_after;
                    if (cmd.insert) seq_reg <= seq_reg + 32'd1;
                    ev_reg <= cmd.evict;
                    ek_reg <= cmd.evict ? vic_key_c[ENTRIES] : '0;
                end
                ST_EMIT:
                begin
                    out_valid  <= 1'b1;
                    evicted    <= 1'b0;
                    evicted_key <= '0;
                    read_value <= '0;
                    status     <= lfu_pkg::STATUS_OK;
                    last       <= 1'b1;
                    case (func_reg)
                        lfu_pkg::FUNC_GET:
                        begin
                            if (hit) read_value <= hit_val_c[ENTRIES];
                            else status <= lfu_pkg::STATUS_MISS;
                        end
                        lfu_pkg::FUNC_PUT:
                        begin
                            evicted     <= ev_reg;
                            evicted_key <= ek_reg;
                        end
                        lfu_pkg::FUNC_POP:
                        begin
                            if (left_reg == 5'd0) ;
                            else if (!ev_reg) status <= lfu_pkg::STATUS_POP_OVER;
                            else
                            begin
                                evicted     <= 1'b1;
                                evicted_key <= ek_reg;
                                last        <= (left_reg == 5'd1);
                            end
                        end
                        default: ;
                    endcase
                end
                ST_WAIT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        step_reg <= '0;
                        if (func_reg == lfu_pkg::FUNC_POP && ev_reg && left_reg > 5'd1)
                        begin
                            left_reg <= left_reg - 5'd1;
                            ev_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the LFU key-value cache unit
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    localparam int SLOTS = lfu_pkg::ENTRIES;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [4:0]  occupancy;
        logic        last;
    } cache_result_t;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
        logic [4:0]  count;
        logic        fixed;
        logic [1:0]  want_status;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [31:0] lookup_key = '0;
    logic [31:0] put_value = '0;
    logic [4:0] pop_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [31:0] read_value;
    logic evicted;
    logic [31:0] evicted_key;
    logic [4:0] occupancy;
    logic last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [0:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lfu_key_value_cache_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic        slot_live [SLOTS];
    logic [31:0] slot_k [SLOTS];
    logic [31:0] slot_v [SLOTS];
    logic [15:0] slot_uses [SLOTS];
    logic [31:0] slot_stamp [SLOTS];
    logic [31:0] next_stamp;
    logic [4:0]  cap_reg;

    cache_result_t pending_results[$];
    int error_count = 0;
    int cycles = 0;
    logic stim_done = 1'b0;

    task automatic report(input string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i]) n++;
        return n;
    endfunction

    function automatic int least_used_slot();
        int best;
        logic [31:0] best_age, age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_live[i]) continue;
            age = next_stamp - slot_stamp[i];
            if (best < 0 || slot_uses[i] < slot_uses[best] ||
                (slot_uses[i] == slot_uses[best] && age < best_age))
            begin
                best = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    function automatic int slot_of(input logic [31:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_k[i] == key) return i;
        return -1;
    endfunction

    function automatic void push_result(input logic [1:0] st, input logic [31:0] rv,
                                        input logic ev, input logic [31:0] ek,
                                        input logic lst);
        cache_result_t r;
        r.status = st;
        r.read_value = rv;
        r.evicted = ev;
        r.evicted_key = ek;
        r.occupancy = 5'(live_count());
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_op(input logic [1:0] f, input logic [31:0] key,
                                       input logic [31:0] value, input logic [4:0] n);
        int s, v, cap;
        logic ev;
        logic [31:0] ek;
        case (f)
            lfu_pkg::FUNC_GET:
            begin
                s = slot_of(key);
                if (s < 0)
                    push_result(lfu_pkg::STATUS_MISS, '0, 1'b0, '0, 1'b1);
                else
                begin
                    if (slot_uses[s] != 16'hffff) slot_uses[s]++;
                    push_result(lfu_pkg::STATUS_OK, slot_v[s], 1'b0, '0, 1'b1);
                end
            end
            lfu_pkg::FUNC_PUT:
            begin
                cap = (cap_reg == 0) ? 1 : (cap_reg > SLOTS) ? SLOTS : int'(cap_reg);
                s = slot_of(key);
                if (s >= 0)
                begin
                    slot_v[s] = value;
                    if (slot_uses[s] != 16'hffff) slot_uses[s]++;
                    push_result(lfu_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
                end
                else
                begin
                    ev = 1'b0;
                    ek = '0;
                    if (live_count() >= cap)
                    begin
                        v = least_used_slot();
                        if (v >= 0)
                        begin
                            ev = 1'b1;
                            ek = slot_k[v];
                            slot_live[v] = 1'b0;
                        end
                    end
                    s = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (s < 0 && !slot_live[i]) s = i;
                    if (s >= 0)
                    begin
                        slot_live[s] = 1'b1;
                        slot_k[s] = key;
                        slot_v[s] = value;
                        slot_uses[s] = 16'd1;
                        slot_stamp[s] = next_stamp;
                        next_stamp++;
                    end
                    push_result(lfu_pkg::STATUS_OK, '0, ev, ek, 1'b1);
                end
            end
            lfu_pkg::FUNC_POP:
            begin
                if (int'(n) > live_count())
                    push_result(lfu_pkg::STATUS_POP_OVER, '0, 1'b0, '0, 1'b1);
                else if (n == 0)
                    push_result(lfu_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
                else
                    for (int k = 0; k < n; k++)
                    begin
                        v = least_used_slot();
                        ek = '0;
                        if (v >= 0)
                        begin
                            ek = slot_k[v];
                            slot_live[v] = 1'b0;
                        end
                        push_result(lfu_pkg::STATUS_OK, '0, 1'b1, ek, k + 1 == n);
                    end
            end
            default: push_result(lfu_pkg::STATUS_OK, '0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    task automatic write_capacity(input logic [4:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= lfu_pkg::REG_CAPACITY;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cap_reg = value;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // drive one beat and predict its results once it is taken
    task automatic send_op(input logic [1:0] f, input logic [31:0] key,
                           input logic [31:0] value, input logic [4:0] n,
                           input bit idle_ok);
        int gap;
        gap = (idle_ok && $urandom_range(3) != 0) ? $urandom_range(13) : 0;
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        func <= f;
        lookup_key <= key;
        put_value <= value;
        pop_count <= n;
        do @(posedge clk); while (in_stall);
        predict_op(f, key, value, n);
        in_valid <= 1'b0;
        // the unit stalls its input after taking a beat
        @(posedge clk);
    endtask

    // pick a key from a small pool so that hits and repeats are common
    function automatic logic [31:0] pool_key();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hffff_fff0 | 32'($urandom_range(3));
            default: return 32'($urandom_range(23));
        endcase
    endfunction

    stim_row_t directed[$];

    initial
    begin
        logic [4:0] caps [7];
        int r;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_k[i] = '0;
            slot_v[i] = '0;
            slot_uses[i] = '0;
            slot_stamp[i] = '0;
        end
        next_stamp = '0;
        cap_reg = 5'd16;
        caps = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd16};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        directed = '{
            '{lfu_pkg::FUNC_GET, 32'h0, 32'h0, 5'd0, 1'b1, lfu_pkg::STATUS_MISS},
            '{lfu_pkg::FUNC_POP, 32'h0, 32'h0, 5'd0, 1'b1, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_POP, 32'h0, 32'h0, 5'd1, 1'b1, lfu_pkg::STATUS_POP_OVER},
            '{FUNC_SPARE, 32'hffffffff, 32'hffffffff, 5'd31, 1'b1, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_PUT, 32'h0, 32'hffffffff, 5'd0, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_PUT, 32'hffffffff, 32'h0, 5'd31, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_PUT, 32'ha5a5a5a5, 32'h5a5a5a5a, 5'd0, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_GET, 32'hffffffff, 32'h0, 5'd0, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_GET, 32'h0, 32'h0, 5'd0, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_PUT, 32'h0, 32'h12345678, 5'd0, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_GET, 32'h0, 32'h0, 5'd0, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_GET, 32'h1, 32'h0, 5'd0, 1'b1, lfu_pkg::STATUS_MISS},
            '{lfu_pkg::FUNC_POP, 32'h0, 32'h0, 5'd4, 1'b1, lfu_pkg::STATUS_POP_OVER},
            '{lfu_pkg::FUNC_POP, 32'h0, 32'h0, 5'd2, 1'b0, lfu_pkg::STATUS_OK},
            '{lfu_pkg::FUNC_POP, 32'h0, 32'h0, 5'd1, 1'b0, lfu_pkg::STATUS_OK}
        };
        foreach (directed[i])
        begin
            send_op(directed[i].func, directed[i].key, directed[i].value,
                    directed[i].count, 1'b1);
            // fixed rows give a single result, the newest one queued
            if (directed[i].fixed &&
                pending_results[pending_results.size() - 1].status != directed[i].want_status)
                report($sformatf("directed row %0d predicts wrong status", i));
        end

        // fill to the full array, then pop it all in one beat
        for (int i = 0; i < SLOTS; i++)
            send_op(lfu_pkg::FUNC_PUT, 32'(100 + i), $urandom, 5'd0, 1'b1);
        send_op(lfu_pkg::FUNC_PUT, 32'd999, 32'd1, 5'd0, 1'b1);
        send_op(lfu_pkg::FUNC_POP, 32'd0, 32'd0, 5'd16, 1'b1);
        drain();

        // sweep capacity through its extremes, including out-of-range values
        for (int phase = 0; phase < 7; phase++)
        begin
            write_capacity(caps[phase]);
            for (int i = 0; i < 56; i++)
            begin
                r = $urandom_range(9);
                if (r < 5)
                    send_op(lfu_pkg::FUNC_PUT, pool_key(), $urandom, 5'($urandom), 1'b1);
                else if (r < 8)
                    send_op(lfu_pkg::FUNC_GET, pool_key(), $urandom, 5'($urandom), 1'b1);
                else if (r < 9)
                    send_op(lfu_pkg::FUNC_POP, $urandom, $urandom,
                            5'($urandom_range(live_count() + 1)), 1'b1);
                else
                    send_op(2'($urandom), $urandom, $urandom, 5'($urandom), 1'b1);
                // hold off until the output side has caught up
                if (i == 28)
                    while (pending_results.size() != 0) @(posedge clk);
            end
            drain();
        end
        stim_done = 1'b1;
    end

    // output side: random stall per beat, with bursts of none
    initial
    begin
        int wait_cycles;
        wait_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                wait_cycles = ($urandom_range(4) == 0) ? 0 : $urandom_range(13);
            else if (wait_cycles > 0)
                wait_cycles--;
            out_stall <= (wait_cycles > 0);
        end
    end

    always @(posedge clk)
    begin
        cache_result_t got, want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, read_value, evicted, evicted_key, occupancy, last};
            if (pending_results.size() == 0)
                report("result with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report($sformatf("status %0d want %0d", got.status, want.status));
                if (got.read_value != want.read_value)
                    report($sformatf("read_value %h want %h", got.read_value,
                                     want.read_value));
                if (got.evicted != want.evicted)
                    report($sformatf("evicted %0d want %0d", got.evicted, want.evicted));
                if (got.evicted_key != want.evicted_key)
                    report($sformatf("evicted_key %h want %h", got.evicted_key,
                                     want.evicted_key));
                if (got.occupancy != want.occupancy)
                    report($sformatf("occupancy %0d want %0d", got.occupancy,
                                     want.occupancy));
                if (got.last != want.last)
                    report($sformatf("last %0d want %0d", got.last, want.last));
            end
        end
    end

    initial
    begin
        wait (stim_done);
        if (pending_results.size() != 0)
            report("expected results left over");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
